@@ rtl/ktd_pkg.sv @@
// Package for the keypad ticket dispense controller.
// Holds the beat payload types, key and event codes and the controller state type.
// Used by ktd_core and keypad_ticket_dispense_controller_top.
package ktd_pkg;

  localparam int unsigned ValueW   = 14;
  localparam int unsigned DigitW   = 3;
  localparam int unsigned KeyW     = 4;
  localparam int unsigned SecondsW = 4;

  // request length limit, 1 to 4 digits
  localparam logic [DigitW-1:0] MaxDigits = DigitW'(4);

  localparam logic [KeyW-1:0] KeyStar    = KeyW'(10);
  localparam logic [KeyW-1:0] KeyHash    = KeyW'(11);
  localparam logic [KeyW-1:0] KeyLastDig = KeyW'(9);
  localparam logic [KeyW-1:0] KeyZero    = KeyW'(0);

  localparam logic [SecondsW-1:0] TimeoutReset = SecondsW'(3);
  localparam logic [SecondsW-1:0] IdleMax      = SecondsW'(15);

  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvDone     = 3'd1,
    EvCancel   = 3'd2,
    EvTimeout  = 3'd3,
    EvOverflow = 3'd4,
    EvEmpty    = 3'd5
  } event_e;

  typedef struct packed {
    logic            key_valid;
    logic [KeyW-1:0] key_code;
    logic            opto_level;
    logic            second_tick;
  } in_item_t;

  typedef struct packed {
    logic              motor_on;
    logic [ValueW-1:0] display_value;
    logic              dispensing;
    logic [2:0]        event_code;
  } out_item_t;

  typedef struct packed {
    logic [ValueW-1:0]   entered_value;
    logic [DigitW-1:0]   digit_count;
    logic [ValueW-1:0]   dispensed_count;
    logic                prior_opto_high;
    logic                mode_dispensing;
    logic [SecondsW-1:0] idle_seconds;
  } ctrl_state_t;

endpackage

@@ rtl/ktd_core.sv @@
// Controller state registers and the per-sample update logic.
// Takes one registered sample beat when step_i is high and gives its result.
// Depends on ktd_pkg.
module ktd_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  ktd_pkg::in_item_t               item_i,
  input  logic [ktd_pkg::SecondsW-1:0]    timeout_i,
  output ktd_pkg::out_item_t              result_o
);

  ktd_pkg::ctrl_state_t state_q, state_d;
  ktd_pkg::event_e      ev;

  logic                         edge_seen;
  logic [ktd_pkg::ValueW-1:0]   count_inc;
  logic [ktd_pkg::SecondsW-1:0] idle_after_edge;
  logic [ktd_pkg::SecondsW-1:0] idle_after_tick;
  logic [ktd_pkg::ValueW-1:0]   value_times_ten;

  assign value_times_ten = (state_q.entered_value << 3) + (state_q.entered_value << 1)
                         + ktd_pkg::ValueW'(item_i.key_code);

  assign edge_seen       = state_q.prior_opto_high & ~item_i.opto_level;
  assign count_inc       = edge_seen ? state_q.dispensed_count + ktd_pkg::ValueW'(1)
                                     : state_q.dispensed_count;
  assign idle_after_edge = edge_seen ? '0 : state_q.idle_seconds;
  assign idle_after_tick = (item_i.second_tick && idle_after_edge < ktd_pkg::IdleMax)
                         ? idle_after_edge + ktd_pkg::SecondsW'(1) : idle_after_edge;

  always_comb begin
    state_d = state_q;
    ev      = ktd_pkg::EvNone;
    if (state_q.mode_dispensing) begin
      state_d.prior_opto_high = item_i.opto_level;
      state_d.dispensed_count = count_inc;
      state_d.idle_seconds    = idle_after_tick;
      if (edge_seen && count_inc == state_q.entered_value) begin
        state_d = '0;
        ev      = ktd_pkg::EvDone;
      end else if (idle_after_tick >= timeout_i) begin
        state_d = '0;
        ev      = ktd_pkg::EvTimeout;
      end else if (item_i.key_valid && item_i.key_code == ktd_pkg::KeyStar) begin
        state_d = '0;
        ev      = ktd_pkg::EvCancel;
      end
    end else if (item_i.key_valid) begin
      if (item_i.key_code == ktd_pkg::KeyStar) begin
        state_d = '0;
        ev      = ktd_pkg::EvCancel;
      end else if (item_i.key_code == ktd_pkg::KeyHash) begin
        if (state_q.entered_value == '0) begin
          state_d = '0;
          ev      = ktd_pkg::EvEmpty;
        end else begin
          state_d.mode_dispensing = 1'b1;
          state_d.dispensed_count = '0;
          state_d.idle_seconds    = '0;
          state_d.prior_opto_high = item_i.opto_level;
        end
      end else if (item_i.key_code > ktd_pkg::KeyLastDig) begin
        ev = ktd_pkg::EvNone;
      end else if (state_q.digit_count == '0 && item_i.key_code == ktd_pkg::KeyZero) begin
        // leading zero is dropped
        ev = ktd_pkg::EvNone;
      end else if (state_q.digit_count >= ktd_pkg::MaxDigits) begin
        state_d = '0;
        ev      = ktd_pkg::EvOverflow;
      end else begin
        state_d.entered_value = value_times_ten;
        state_d.digit_count   = state_q.digit_count + ktd_pkg::DigitW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    result_o.motor_on      = state_d.mode_dispensing;
    result_o.dispensing    = state_d.mode_dispensing;
    result_o.display_value = state_d.mode_dispensing ? state_d.dispensed_count
                                                     : state_d.entered_value;
    result_o.event_code    = ev;
  end

endmodule

@@ rtl/keypad_ticket_dispense_controller_top.sv @@
// Top level of the keypad ticket dispense controller.
// Input beat register, timeout register, ktd_core and the result register.
// Depends on ktd_pkg and ktd_core.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------
//  in      | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//  out     | out_valid_o/ out_stall_i| out_data_o (out_item_t)
//  cfg     | cfg_we_i                | cfg_wdata_i (timeout, s)
//
// one sample beat per cycle while the result register is not stalled; a beat is
// registered in the input register, then processed into the result register.
// the controller state updates only when the result register can take the beat.
// reset clears state, empties both registers and sets the timeout to 3 s.
// out_stall_i holds the result register, and in_stall_o rises only while the
// input register is full and cannot move on.
module keypad_ticket_dispense_controller_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ktd_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ktd_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [ktd_pkg::SecondsW-1:0] cfg_wdata_i
);

  logic                         in_valid_q;
  ktd_pkg::in_item_t            in_data_q;
  logic                         out_valid_q;
  ktd_pkg::out_item_t           out_data_q;
  logic [ktd_pkg::SecondsW-1:0] timeout_q;
  logic                         advance;
  logic                         step;
  ktd_pkg::out_item_t           result;

  assign advance    = ~out_valid_q | ~out_stall_i;
  assign step       = in_valid_q & advance;
  assign in_stall_o = in_valid_q & ~advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ktd_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  ktd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_data_q),
    .timeout_i (timeout_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
